// File: rtl/sprt_pkg.sv
// ----------------------------------------------------------------------------
// sprt_pkg
// Shared types and constants of the sorted peer ring table: request and
// status codes, and the command and status words between controller and
// datapath.
// ----------------------------------------------------------------------------
package sprt_pkg;

  localparam int PORT_W    = 16;
  localparam int IP_W      = 32;
  localparam int CNT_OUT_W = 7;

  // request codes
  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_NEIGHBOR = 2'd2,
    REQ_COUNT    = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // load sources of the table pointer
  typedef enum logic [2:0] {
    PTR_ZERO,
    PTR_LAST,
    PTR_POS_P1,
    PTR_PREV,
    PTR_NEXT
  } ptr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic     req_ld;
    logic     ptr_ld;
    ptr_sel_t ptr_sel;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     rd_en;
    logic     mv_up;
    logic     mv_dn;
    logic     scan;
    logic     wr_new;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     st_ld;
    status_t  st_val;
    logic     cap_prev;
    logic     cap_next;
    logic     out_ld;
  } sprt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req;
    logic hit;
    logic rd_vld;
    logic ptr_lt_cnt;
    logic ptr_eq_pos;
    logic ptr_eq_last;
    logic present;
    logic pos_eq_cnt;
    logic pos_p1_eq_cnt;
    logic full;
    logic cnt_zero;
    logic out_free;
  } sprt_sts_t;

endpackage

// File: rtl/sprt_if.sv
// ----------------------------------------------------------------------------
// sprt_req_if / sprt_rsp_if
// Valid/ready channels of the peer ring table: request word in, result
// word out.
// ----------------------------------------------------------------------------
interface sprt_req_if import sprt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [PORT_W-1:0] port;
  logic [IP_W-1:0]   peer_ip;

  modport source (output valid, output req_type, output port, output peer_ip, input ready);
  modport sink   (input valid, input req_type, input port, input peer_ip, output ready);
endinterface

interface sprt_rsp_if import sprt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 has_prev;
  logic [PORT_W-1:0]    prev_port;
  logic [IP_W-1:0]      prev_ip;
  logic                 has_next;
  logic [PORT_W-1:0]    next_port;
  logic [IP_W-1:0]      next_ip;
  logic [CNT_OUT_W-1:0] peer_count;

  modport source (output valid, output status, output has_prev, output prev_port,
                  output prev_ip, output has_next, output next_port, output next_ip,
                  output peer_count, input ready);
  modport sink   (input valid, input status, input has_prev, input prev_port,
                  input prev_ip, input has_next, input next_port, input next_ip,
                  input peer_count, output ready);
endinterface

// File: rtl/sorted_peer_ring_table.sv
// ----------------------------------------------------------------------------
// sorted_peer_ring_table
// Table of up to MAX_PEERS peers sorted by port, read as a ring.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  (valid/ready): one request word: req_type, port, peer_ip.
//           Register, remove, neighbor query or count query.
//   out_rsp (valid/ready): one result word per request: status, the
//           previous and next ring neighbors (queries only) and the peer
//           count after the request.
//   One request is worked at a time. Every request first walks the sorted
//   entries from index 0 at one entry per cycle (single read port, registered
//   read) until a key not below the port turns up. A register or remove then
//   shifts the entries above the position by one place, again one entry per
//   cycle. A neighbor query then reads its two ring neighbors. in_ready is high
//   whenever no request is in work, also while a result waits in the output
//   register; a stalled receiver holds the result and the next request then
//   waits at the end of its work.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_peer_ring_table import sprt_pkg::*; #(
  parameter int MAX_PEERS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  sprt_req_if.sink   in_req,
  sprt_rsp_if.source out_rsp
);

  sprt_cmd_t cmd;
  sprt_sts_t sts;
  logic      ctl_ready;

  assign in_req.ready = ctl_ready;

  // sequencer
  sprt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (ctl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and result datapath
  sprt_dp #(
    .MAX_PEERS (MAX_PEERS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req.req_type),
    .in_port        (in_req.port),
    .in_peer_ip     (in_req.peer_ip),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_rsp.ready),
    .out_valid      (out_rsp.valid),
    .out_status     (out_rsp.status),
    .out_has_prev   (out_rsp.has_prev),
    .out_prev_port  (out_rsp.prev_port),
    .out_prev_ip    (out_rsp.prev_ip),
    .out_has_next   (out_rsp.has_next),
    .out_next_port  (out_rsp.next_port),
    .out_next_ip    (out_rsp.next_ip),
    .out_peer_count (out_rsp.peer_count)
  );

endmodule

// File: rtl/sprt_ctrl.sv
// ----------------------------------------------------------------------------
// sprt_ctrl
// Request sequencer: search walk, insert/remove shift, neighbor reads and
// result hand-off. Drives the datapath by command word only.
// ----------------------------------------------------------------------------
module sprt_ctrl import sprt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sprt_sts_t sts,
  output sprt_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_DECIDE,
    S_INS,
    S_INS_DRAIN,
    S_WR_NEW,
    S_DEL,
    S_DEL_DRAIN,
    S_Q_PREV,
    S_Q_NEXT,
    S_Q_CAP,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st_val  = ST_OK;
    cmd.ptr_sel = PTR_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_ld  = 1'b1;
          cmd.st_ld   = 1'b1;
          cmd.st_val  = ST_OK;
          cmd.ptr_ld  = 1'b1;
          cmd.ptr_sel = PTR_ZERO;
          state_nxt   = S_SRCH;
        end
      end
      // walk up the sorted keys until one is not below the port or the entries run out
      S_SRCH: begin
        cmd.scan    = 1'b1;
        cmd.rd_en   = sts.ptr_lt_cnt && !sts.hit;
        cmd.ptr_inc = sts.ptr_lt_cnt && !sts.hit;
        if (sts.hit || (!sts.ptr_lt_cnt && !sts.rd_vld)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (sts.req)
          REQ_REGISTER: begin
            if (sts.present) begin
              cmd.st_ld  = 1'b1;
              cmd.st_val = ST_DUP;
              state_nxt  = S_RESP;
            end else if (sts.full) begin
              cmd.st_ld  = 1'b1;
              cmd.st_val = ST_FULL;
              state_nxt  = S_RESP;
            end else if (sts.pos_eq_cnt) begin
              state_nxt  = S_WR_NEW;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_sel = PTR_LAST;
              state_nxt   = S_INS;
            end
          end
          REQ_REMOVE: begin
            if (!sts.present) begin
              cmd.st_ld  = 1'b1;
              cmd.st_val = ST_ABSENT;
              state_nxt  = S_RESP;
            end else if (sts.pos_p1_eq_cnt) begin
              cmd.cnt_dec = 1'b1;
              state_nxt   = S_RESP;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_sel = PTR_POS_P1;
              state_nxt   = S_DEL;
            end
          end
          REQ_NEIGHBOR: begin
            if (sts.cnt_zero) begin
              state_nxt = S_RESP;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_sel = PTR_PREV;
              state_nxt   = S_Q_PREV;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      // move entries one place up, from the top down to the insert point
      S_INS: begin
        cmd.rd_en = 1'b1;
        cmd.mv_up = 1'b1;
        if (sts.ptr_eq_pos) begin
          state_nxt = S_INS_DRAIN;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_INS_DRAIN: begin
        state_nxt = S_WR_NEW;
      end
      S_WR_NEW: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_RESP;
      end
      // move entries above the removed one down by one place
      S_DEL: begin
        cmd.rd_en = 1'b1;
        cmd.mv_dn = 1'b1;
        if (sts.ptr_eq_last) begin
          state_nxt = S_DEL_DRAIN;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_DEL_DRAIN: begin
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_RESP;
      end
      // neighbor reads
      S_Q_PREV: begin
        cmd.rd_en   = 1'b1;
        cmd.ptr_ld  = 1'b1;
        cmd.ptr_sel = PTR_NEXT;
        state_nxt   = S_Q_NEXT;
      end
      S_Q_NEXT: begin
        cmd.rd_en    = 1'b1;
        cmd.cap_prev = 1'b1;
        state_nxt    = S_Q_CAP;
      end
      S_Q_CAP: begin
        cmd.cap_next = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/sprt_dp.sv
// ----------------------------------------------------------------------------
// sprt_dp
// Datapath of the peer ring table: sorted entry memory, pointer, search
// compare, shift engine, neighbor index math and the result register.
// ----------------------------------------------------------------------------
module sprt_dp import sprt_pkg::*; #(
  parameter int MAX_PEERS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_req_type,
  input  logic [PORT_W-1:0]    in_port,
  input  logic [IP_W-1:0]      in_peer_ip,
  input  sprt_cmd_t            cmd,
  output sprt_sts_t            sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic                 out_has_prev,
  output logic [PORT_W-1:0]    out_prev_port,
  output logic [IP_W-1:0]      out_prev_ip,
  output logic                 out_has_next,
  output logic [PORT_W-1:0]    out_next_port,
  output logic [IP_W-1:0]      out_next_ip,
  output logic [CNT_OUT_W-1:0] out_peer_count
);

  localparam int CNT_W = $clog2(MAX_PEERS + 1);
  localparam int IDX_W = $clog2(MAX_PEERS);
  localparam int ENT_W = PORT_W + IP_W;
  localparam logic [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PEERS);

  // entry memory: {port, address}, sorted by port
  logic [ENT_W-1:0] mem [MAX_PEERS];

  req_t              req_r;
  logic [PORT_W-1:0] port_r;
  logic [IP_W-1:0]   ip_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  pos_r;
  logic              present_r;
  status_t           st_r;
  logic [ENT_W-1:0]  rd_data_r;
  logic [CNT_W-1:0]  rd_addr_r;
  logic              rd_vld_r, rd_up_r, rd_dn_r;
  logic [ENT_W-1:0]  prev_r, next_r;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic                 out_has_prev_r, out_has_next_r;
  logic [PORT_W-1:0]    out_prev_port_r, out_next_port_r;
  logic [IP_W-1:0]      out_prev_ip_r, out_next_ip_r;
  logic [CNT_OUT_W-1:0] out_peer_count_r;

  logic [PORT_W-1:0]    rd_key;
  logic [CNT_W-1:0]     cnt_m1, pos_p1, prev_idx, next_idx;
  logic                 hit, pos_eq_cnt;
  logic                 wr_en;
  logic [CNT_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;
  logic                 has_prev, has_next, is_query;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign rd_key     = rd_data_r[ENT_W-1 -: PORT_W];
  assign cnt_m1     = cnt_r - CNT_ONE;
  assign pos_p1     = pos_r + CNT_ONE;
  assign hit        = rd_vld_r && (rd_key >= port_r);
  assign pos_eq_cnt = (pos_r == cnt_r);

  // ring neighbors of the search position
  assign prev_idx = (pos_r == CNT_ZERO) ? cnt_m1 : (pos_r - CNT_ONE);
  always_comb begin
    if (present_r) begin
      next_idx = (pos_p1 == cnt_r) ? CNT_ZERO : pos_p1;
    end else begin
      next_idx = pos_eq_cnt ? CNT_ZERO : pos_r;
    end
  end

  // reported neighbors; one peer drops one side (both for its own port), two peers one side for a present port
  assign is_query = (req_r == REQ_NEIGHBOR);
  assign has_prev = is_query && (cnt_r != CNT_ZERO)
                    && !((cnt_r == CNT_ONE) && (present_r || (pos_r == CNT_ZERO)))
                    && !((cnt_r == CNT_TWO) && present_r && (pos_r == CNT_ZERO));
  assign has_next = is_query && (cnt_r != CNT_ZERO)
                    && !((cnt_r == CNT_ONE) && (present_r || (pos_r != CNT_ZERO)))
                    && !((cnt_r == CNT_TWO) && present_r && (pos_r != CNT_ZERO));

  // status to controller
  always_comb begin
    sts               = '0;
    sts.req           = req_r;
    sts.hit           = hit;
    sts.rd_vld        = rd_vld_r;
    sts.ptr_lt_cnt    = (ptr_r < cnt_r);
    sts.ptr_eq_pos    = (ptr_r == pos_r);
    sts.ptr_eq_last   = (ptr_r == cnt_m1);
    sts.present       = present_r;
    sts.pos_eq_cnt    = pos_eq_cnt;
    sts.pos_p1_eq_cnt = (pos_p1 == cnt_r);
    sts.full          = (cnt_r == CNT_MAX);
    sts.cnt_zero      = (cnt_r == CNT_ZERO);
    sts.out_free      = !out_valid_r || out_ready;
  end

  // pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_ld) begin
      unique case (cmd.ptr_sel)
        PTR_ZERO:   ptr_nxt = CNT_ZERO;
        PTR_LAST:   ptr_nxt = cnt_m1;
        PTR_POS_P1: ptr_nxt = pos_p1;
        PTR_PREV:   ptr_nxt = prev_idx;
        PTR_NEXT:   ptr_nxt = next_idx;
        default:    ptr_nxt = CNT_ZERO;
      endcase
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + CNT_ONE;
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_r - CNT_ONE;
    end
  end

  // peer count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_ONE;
    end
  end

  // memory write: shifted entry or the new entry
  always_comb begin
    wr_en   = cmd.wr_new || (rd_vld_r && (rd_up_r || rd_dn_r));
    wr_data = rd_data_r;
    wr_addr = rd_up_r ? (rd_addr_r + CNT_ONE) : (rd_addr_r - CNT_ONE);
    if (cmd.wr_new) begin
      wr_addr = pos_r;
      wr_data = {port_r, ip_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[ptr_r[IDX_W-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CNT_ZERO;
      rd_vld_r    <= 1'b0;
      rd_up_r     <= 1'b0;
      rd_dn_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_vld_r <= cmd.rd_en;
      rd_up_r  <= cmd.rd_en && cmd.mv_up;
      rd_dn_r  <= cmd.rd_en && cmd.mv_dn;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_r};

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    rd_addr_r <= ptr_r;
    if (cmd.req_ld) begin
      req_r  <= req_t'(in_req_type);
      port_r <= in_port;
      ip_r   <= in_peer_ip;
    end
    if (cmd.st_ld) begin
      st_r <= cmd.st_val;
    end
    // search result: first key not below the port, else the count
    if (cmd.scan) begin
      pos_r     <= hit ? rd_addr_r : cnt_r;
      present_r <= hit && (rd_key == port_r);
    end
    if (cmd.cap_prev) begin
      prev_r <= rd_data_r;
    end
    if (cmd.cap_next) begin
      next_r <= rd_data_r;
    end
    if (cmd.out_ld) begin
      out_status_r     <= st_r;
      out_has_prev_r   <= has_prev;
      out_has_next_r   <= has_next;
      out_prev_port_r  <= has_prev ? prev_r[ENT_W-1 -: PORT_W] : '0;
      out_prev_ip_r    <= has_prev ? prev_r[IP_W-1:0] : '0;
      out_next_port_r  <= has_next ? next_r[ENT_W-1 -: PORT_W] : '0;
      out_next_ip_r    <= has_next ? next_r[IP_W-1:0] : '0;
      out_peer_count_r <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_has_prev   = out_has_prev_r;
  assign out_prev_port  = out_prev_port_r;
  assign out_prev_ip    = out_prev_ip_r;
  assign out_has_next   = out_has_next_r;
  assign out_next_port  = out_next_port_r;
  assign out_next_ip    = out_next_ip_r;
  assign out_peer_count = out_peer_count_r;

endmodule

// File: rtl/sprt_checker.sv
// ----------------------------------------------------------------------------
// sprt_checker
// Port-level checks of the peer ring table, bound to the top level.
// ----------------------------------------------------------------------------
module sprt_checker import sprt_pkg::*; #(
  parameter int MAX_PEERS = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic                 out_has_prev,
  input logic [PORT_W-1:0]    out_prev_port,
  input logic [IP_W-1:0]      out_prev_ip,
  input logic                 out_has_next,
  input logic [PORT_W-1:0]    out_next_port,
  input logic [IP_W-1:0]      out_next_ip,
  input logic [CNT_OUT_W-1:0] out_peer_count
);

  localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(MAX_PEERS);

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
                                && $stable(out_peer_count))
    else $error("stalled result word changed");

  // failed requests report no neighbors
  a_err_no_nbr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_has_prev && !out_has_next)
    else $error("neighbor reported on a failed request");

  // absent neighbor fields read zero
  a_nbr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_prev || ((out_prev_port == '0) && (out_prev_ip == '0)))
                  && (out_has_next || ((out_next_port == '0) && (out_next_ip == '0))))
    else $error("neighbor fields not zero without a neighbor");

  // a full table reports the full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_peer_count == FULL_CNT)
    else $error("table full with a short peer count");

endmodule

bind sorted_peer_ring_table sprt_checker #(
  .MAX_PEERS (MAX_PEERS)
) u_sprt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_status     (out_rsp.status),
  .out_has_prev   (out_rsp.has_prev),
  .out_prev_port  (out_rsp.prev_port),
  .out_prev_ip    (out_rsp.prev_ip),
  .out_has_next   (out_rsp.has_next),
  .out_next_port  (out_rsp.next_port),
  .out_next_ip    (out_rsp.next_ip),
  .out_peer_count (out_rsp.peer_count)
);

// File: dv/tb_sorted_peer_ring_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_peer_ring_table
// Self-checking bench for the sorted peer ring table. A short directed run
// walks the empty, one-peer, two-peer and ring cases. It is followed by
// random fill, drain and churn runs that reach the full table. Each result
// word is checked field by field against an in-bench table model, under
// random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_peer_ring_table;
  import sprt_pkg::*;

  localparam int MAX_PEERS    = 64;
  localparam int ITEMS        = 1450;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int MAX_PRINTS   = 30;

  typedef struct packed {
    req_t              kind;
    logic [PORT_W-1:0] port;
    logic [IP_W-1:0]   ip;
  } ring_req_t;

  typedef struct packed {
    status_t              status;
    logic                 has_prev;
    logic [PORT_W-1:0]    prev_port;
    logic [IP_W-1:0]      prev_ip;
    logic                 has_next;
    logic [PORT_W-1:0]    next_port;
    logic [IP_W-1:0]      next_ip;
    logic [CNT_OUT_W-1:0] peer_count;
  } ring_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // bench-side drive values, known from time zero
  logic              drv_valid = 1'b0;
  logic [1:0]        drv_kind  = '0;
  logic [PORT_W-1:0] drv_port  = '0;
  logic [IP_W-1:0]   drv_ip    = '0;
  logic              mon_ready = 1'b0;

  sprt_req_if req_bus ();
  sprt_rsp_if rsp_bus ();

  assign req_bus.valid    = drv_valid;
  assign req_bus.req_type = drv_kind;
  assign req_bus.port     = drv_port;
  assign req_bus.peer_ip  = drv_ip;
  assign rsp_bus.ready    = mon_ready;

  sorted_peer_ring_table #(.MAX_PEERS(MAX_PEERS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  always #1 clk = ~clk;

  // stimulus and expectation stores
  ring_req_t         stim_q[$];
  ring_rsp_t         pending_results[$];
  logic [PORT_W-1:0] gen_ports[$];
  int                stim_total   = 0;
  int                acc_cnt      = 0;
  int                results_seen = 0;
  int                err_cnt      = 0;
  int                cycle_cnt    = 0;

  // table model
  logic [PORT_W-1:0] tbl_key[MAX_PEERS];
  logic [IP_W-1:0]   tbl_ip[MAX_PEERS];
  int                tbl_used = 0;
  int                n_dup = 0, n_full = 0, n_absent = 0, n_query = 0, peak_used = 0;

  // idling per phase: sender light/receiver heavy, then swapped, then none
  int send_idle_pct, rcv_idle_pct;
  assign send_idle_pct = (acc_cnt < stim_total / 3) ? 6 :
                         (acc_cnt < 2 * stim_total / 3) ? 47 : 0;
  assign rcv_idle_pct  = (acc_cnt < stim_total / 3) ? 47 :
                         (acc_cnt < 2 * stim_total / 3) ? 6 : 0;

  // Apply one request to the table model and return the expected result.
  function automatic ring_rsp_t ring_table_apply(ring_req_t r);
    ring_rsp_t res;
    int        pos, pi, ni, nx;
    bit        present;
    res = '0;
    pi  = -1;
    ni  = -1;
    pos = 0;
    while (pos < tbl_used && tbl_key[pos] < r.port) pos++;
    present = (pos < tbl_used) && (tbl_key[pos] == r.port);
    case (r.kind)
      REQ_REGISTER: begin
        if (present) begin
          res.status = ST_DUP;
          n_dup++;
        end else if (tbl_used >= MAX_PEERS) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          for (int k = tbl_used; k > pos; k--) begin
            tbl_key[k] = tbl_key[k-1];
            tbl_ip[k]  = tbl_ip[k-1];
          end
          tbl_key[pos] = r.port;
          tbl_ip[pos]  = r.ip;
          tbl_used++;
        end
      end
      REQ_REMOVE: begin
        if (!present) begin
          res.status = ST_ABSENT;
          n_absent++;
        end else begin
          for (int k = pos; k + 1 < tbl_used; k++) begin
            tbl_key[k] = tbl_key[k+1];
            tbl_ip[k]  = tbl_ip[k+1];
          end
          tbl_used--;
        end
      end
      REQ_NEIGHBOR: begin
        n_query++;
        if (tbl_used == 1) begin
          if (r.port > tbl_key[0]) pi = 0;
          else if (r.port < tbl_key[0]) ni = 0;
        end else if (tbl_used == 2) begin
          // two peers: present port sees only the other side
          if (present) begin
            if (pos == 0) ni = 1;
            else pi = 0;
          end else if (r.port > tbl_key[0] && r.port < tbl_key[1]) begin
            pi = 0;
            ni = 1;
          end else begin
            pi = 1;
            ni = 0;
          end
        end else if (tbl_used >= 3) begin
          if (present) begin
            pi = (pos == 0) ? tbl_used - 1 : pos - 1;
            ni = (pos + 1 == tbl_used) ? 0 : pos + 1;
          end else begin
            nx = (pos >= tbl_used) ? 0 : pos;
            pi = (nx == 0) ? tbl_used - 1 : nx - 1;
            ni = nx;
          end
        end
        if (pi >= 0) begin
          res.has_prev  = 1'b1;
          res.prev_port = tbl_key[pi];
          res.prev_ip   = tbl_ip[pi];
        end
        if (ni >= 0) begin
          res.has_next  = 1'b1;
          res.next_port = tbl_key[ni];
          res.next_ip   = tbl_ip[ni];
        end
      end
      default: ;
    endcase
    if (tbl_used > peak_used) peak_used = tbl_used;
    res.peer_count = tbl_used[CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("[%0t] result %0d: %s got %0h want %0h", $realtime, results_seen, what,
               got, want);
  endtask

  // ---- stimulus helpers (own membership view, only to steer port choice)
  task automatic queue_req(req_t kind, logic [PORT_W-1:0] port, logic [IP_W-1:0] ip);
    ring_req_t r;
    int        idx;
    r.kind = kind;
    r.port = port;
    r.ip   = ip;
    stim_q.push_back(r);
    idx = -1;
    foreach (gen_ports[i]) if (gen_ports[i] == port) idx = i;
    if (kind == REQ_REGISTER && idx < 0 && gen_ports.size() < MAX_PEERS)
      gen_ports.push_back(port);
    else if (kind == REQ_REMOVE && idx >= 0)
      gen_ports.delete(idx);
  endtask

  function automatic logic [PORT_W-1:0] member_port();
    if (gen_ports.size() == 0) return PORT_W'($urandom);
    return gen_ports[$urandom_range(0, gen_ports.size() - 1)];
  endfunction

  function automatic logic [PORT_W-1:0] fresh_port();
    logic [PORT_W-1:0] p;
    bit                hit;
    do begin
      p   = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : PORT_W'($urandom);
      hit = 1'b0;
      foreach (gen_ports[i]) if (gen_ports[i] == p) hit = 1'b1;
    end while (hit);
    return p;
  endfunction

  // query key: members, their neighbors by one, extremes, or anything
  function automatic logic [PORT_W-1:0] probe_port();
    case ($urandom_range(0, 5))
      0:       return member_port();
      1:       return member_port() + PORT_W'(1);
      2:       return member_port() - PORT_W'(1);
      3:       return $urandom_range(0, 1) ? '1 : '0;
      default: return PORT_W'($urandom);
    endcase
  endfunction

  // ---- driver: offers queued request words, predicts at acceptance
  always @(posedge clk) begin
    ring_req_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && req_bus.ready) begin
        pending_results.push_back(ring_table_apply(ring_req_t'({req_t'(drv_kind),
                                                                drv_port, drv_ip})));
        acc_cnt <= acc_cnt + 1;
      end
      if (!drv_valid || req_bus.ready) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = stim_q.pop_front();
          drv_valid <= 1'b1;
          drv_kind  <= nxt.kind;
          drv_port  <= nxt.port;
          drv_ip    <= nxt.ip;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---- long result hold-off, counted down here, fills the block
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---- monitor: random ready, checks each accepted result word
  always @(posedge clk) begin
    ring_rsp_t want;
    if (!rst_n) begin
      mon_ready <= 1'b0;
    end else begin
      mon_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_idle_pct);
      if (rsp_bus.valid && mon_ready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          report_mismatch("word with nothing expected, count", 64'(rsp_bus.peer_count),
                          64'(0));
        end else begin
          want = pending_results.pop_front();
          if (rsp_bus.status !== want.status)
            report_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
          if (rsp_bus.has_prev !== want.has_prev)
            report_mismatch("has_prev", 64'(rsp_bus.has_prev), 64'(want.has_prev));
          if (rsp_bus.prev_port !== want.prev_port)
            report_mismatch("prev_port", 64'(rsp_bus.prev_port), 64'(want.prev_port));
          if (rsp_bus.prev_ip !== want.prev_ip)
            report_mismatch("prev_ip", 64'(rsp_bus.prev_ip), 64'(want.prev_ip));
          if (rsp_bus.has_next !== want.has_next)
            report_mismatch("has_next", 64'(rsp_bus.has_next), 64'(want.has_next));
          if (rsp_bus.next_port !== want.next_port)
            report_mismatch("next_port", 64'(rsp_bus.next_port), 64'(want.next_port));
          if (rsp_bus.next_ip !== want.next_ip)
            report_mismatch("next_ip", 64'(rsp_bus.next_ip), 64'(want.next_ip));
          if (rsp_bus.peer_count !== want.peer_count)
            report_mismatch("peer_count", 64'(rsp_bus.peer_count), 64'(want.peer_count));
        end
      end
    end
  end

  // ---- watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_results.size());
    $display("FAIL");
    $finish;
  end

  // ---- stimulus and end of run
  initial begin
    int target;
    // directed: empty, one peer, two peers, ring wrap, absent keys
    queue_req(REQ_COUNT,    16'h1234, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'h0000, 32'hFFFF_FFFF);
    queue_req(REQ_REMOVE,   16'hFFFF, 32'h0000_0000);
    queue_req(REQ_REGISTER, 16'h8000, 32'hFFFF_FFFF);
    queue_req(REQ_NEIGHBOR, 16'h8000, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'hFFFF, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'h0000, 32'h0000_0000);
    queue_req(REQ_REGISTER, 16'h8000, 32'h0000_0000);
    queue_req(REQ_REGISTER, 16'h0000, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'h0000, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'h8000, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'h4000, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'hFFFF, 32'h0000_0000);
    queue_req(REQ_REGISTER, 16'hFFFF, 32'hA5A5_5A5A);
    queue_req(REQ_NEIGHBOR, 16'h0000, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'hFFFF, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'h8000, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'h8001, 32'h0000_0000);
    queue_req(REQ_REMOVE,   16'h0000, 32'h0000_0000);
    queue_req(REQ_NEIGHBOR, 16'h0001, 32'h0000_0000);
    queue_req(REQ_REMOVE,   16'h1234, 32'h0000_0000);
    queue_req(REQ_COUNT,    16'hFFFF, 32'hFFFF_FFFF);
    queue_req(REQ_REMOVE,   16'h8000, 32'h0000_0000);
    queue_req(REQ_REMOVE,   16'hFFFF, 32'h0000_0000);

    // random: fill to full, drain to a few peers, or churn
    while (stim_q.size() < ITEMS) begin
      case ($urandom_range(0, 7))
        0: begin
          while (gen_ports.size() < MAX_PEERS)
            queue_req(REQ_REGISTER, fresh_port(), $urandom);
          repeat (3) queue_req(REQ_REGISTER, fresh_port(), $urandom);
          queue_req(REQ_REGISTER, member_port(), $urandom);
          repeat (4) queue_req(REQ_NEIGHBOR, probe_port(), $urandom);
          queue_req(REQ_COUNT, PORT_W'($urandom), $urandom);
        end
        1, 2: begin
          target = $urandom_range(0, 3);
          while (gen_ports.size() > target) begin
            if ($urandom_range(0, 3) == 0) queue_req(REQ_NEIGHBOR, probe_port(), $urandom);
            else queue_req(REQ_REMOVE, member_port(), $urandom);
          end
          repeat (3) queue_req(REQ_NEIGHBOR, probe_port(), $urandom);
        end
        default: begin
          repeat (20) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3:
                queue_req(REQ_REGISTER,
                          ($urandom_range(0, 4) == 0) ? member_port() : fresh_port(), $urandom);
              4, 5:
                queue_req(REQ_REMOVE,
                          ($urandom_range(0, 3) == 0) ? probe_port() : member_port(), $urandom);
              6, 7, 8: queue_req(REQ_NEIGHBOR, probe_port(), $urandom);
              default: queue_req(REQ_COUNT, PORT_W'($urandom), $urandom);
            endcase
          end
        end
      endcase
    end
    stim_total = stim_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (acc_cnt < stim_total) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d result words checked, peak table size %0d", stim_total,
             results_seen, peak_used);
    $display("%0d duplicate, %0d full-table, %0d absent-remove rejects, %0d neighbor queries",
             n_dup, n_full, n_absent, n_query);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL");
    end
    $finish;
  end

endmodule
